// ----- hw/rtl/gtp_pkg.sv -----
// Shared types, constants and tables of the go-to-point trapezoid controller.
`default_nettype none
package gtp_pkg;

	localparam int COORD_W    = 16;
	localparam int HEAD_W     = 15;
	localparam int TOL_W      = 12;
	localparam int VEL_W      = 14;
	localparam int ANG_W      = 17;
	localparam int FRAC_SHIFT = 12;
	localparam int FRAC_ONE   = 1 << FRAC_SHIFT;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 14;

	localparam logic [TOL_W-1:0] TOL_RST   = TOL_W'(41);
	localparam logic [VEL_W-1:0] ACCEL_RST = VEL_W'(2048);
	localparam logic [VEL_W-1:0] VMAX_RST  = VEL_W'(8192);
	localparam logic [VEL_W-1:0] GATE_RST  = VEL_W'(819);

	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_LEN     = 24;
	localparam int CORDIC_N     = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
	localparam int HALF_PI_24   = 26353589;

	localparam int DIFF_W = COORD_W + 1;
	localparam int RAD_W  = 2 * DIFF_W;
	localparam int ROOT_W = DIFF_W;
	localparam int REM_W  = ROOT_W + 3;
	localparam int CNT_W  = $clog2((ATAN_LEN > ROOT_W) ? ATAN_LEN : ROOT_W);
	localparam int CV_W   = DIFF_W + 8 + 3;
	localparam int BRG_W  = CV_W - FRAC_SHIFT;

	localparam int SAMPLE_RATE_HZ = 62;
	localparam int RS_VAL   = SAMPLE_RATE_HZ * FRAC_ONE;
	localparam int RSA_W    = $clog2(RS_VAL + (1 << VEL_W));
	localparam int W_W      = VEL_W + RSA_W;
	localparam int WL_W     = (W_W + 1) / 2;
	localparam int AV_W     = 2 * VEL_W;
	localparam int DA_W     = ROOT_W + VEL_W;
	localparam int TWO_R2_W = $clog2(2 * SAMPLE_RATE_HZ * SAMPLE_RATE_HZ + 1);
	localparam int MX_W     = (W_W > DA_W) ? W_W : DA_W;
	localparam int MY_A     = (WL_W > VEL_W) ? WL_W : VEL_W;
	localparam int MY_W     = (MY_A > TWO_R2_W) ? MY_A : TWO_R2_W;
	localparam int P_W      = MX_W + MY_W;
	localparam int CMP_A    = P_W + 2 * FRAC_SHIFT + 1;
	localparam int CMP_W    = ((CMP_A > 2 * W_W) ? CMP_A : 2 * W_W) + 2;
	localparam int NV_W     = VEL_W + 2;

	localparam logic [RSA_W-1:0] RS     = RSA_W'(RS_VAL);
	localparam logic [MY_W-1:0]  TWO_R  = MY_W'(2 * SAMPLE_RATE_HZ);
	localparam logic [MY_W-1:0]  TWO_R2 = MY_W'(2 * SAMPLE_RATE_HZ * SAMPLE_RATE_HZ);

	localparam int STEP_SHIFT = 28;
	localparam int STEP_X_W   = VEL_W + 1;
	localparam int STEP_MUL_W = STEP_SHIFT + 1;
	localparam int STEP_P_W   = STEP_X_W + STEP_MUL_W;
	localparam logic [STEP_MUL_W-1:0] STEP_MUL =
		STEP_MUL_W'(((64'd1 << STEP_SHIFT) + SAMPLE_RATE_HZ - 1) / SAMPLE_RATE_HZ);
	localparam logic [STEP_X_W-1:0] HALF_R = STEP_X_W'(SAMPLE_RATE_HZ / 2);

	localparam int FQ_DEPTH = 2;
	localparam int RQ_DEPTH = 2;

	typedef enum logic {
		KIND_POSE   = 1'b0,
		KIND_TARGET = 1'b1
	} gtp_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOLERANCE,
		REG_MAX_ACCEL,
		REG_MAX_VEL,
		REG_HEADING_GATE
	} gtp_reg_t;

	typedef struct packed {
		gtp_kind_t                  kind;
		logic [COORD_W-1:0]         coord_x;
		logic [COORD_W-1:0]         coord_y;
		logic signed [HEAD_W-1:0]   heading;
	} gtp_item_t;

	typedef struct packed {
		logic [TOL_W-1:0] tolerance;
		logic [VEL_W-1:0] max_accel;
		logic [VEL_W-1:0] max_vel;
		logic [VEL_W-1:0] heading_gate;
	} gtp_cfg_t;

	typedef struct packed {
		logic                     cmd_valid;
		logic [VEL_W-1:0]         linear_vel;
		logic signed [ANG_W-1:0]  angular_vel;
		logic                     arrived;
	} gtp_result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_SQUARE,
		ST_SUM,
		ST_SQRT,
		ST_CHECK,
		ST_CORDIC,
		ST_ERR,
		ST_GATE,
		ST_PROFILE,
		ST_EMIT
	} gtp_state_t;

	typedef enum logic [3:0] {
		PS_W,
		PS_AV,
		PS_WL,
		PS_WH,
		PS_CROSS,
		PS_AA,
		PS_DA,
		PS_FAR,
		PS_DONE
	} gtp_pstep_t;

	// atan(2^-i) in units of 2^-24 rad
	function automatic logic [23:0] atan_lut(input logic [CNT_W-1:0] i);
		logic [23:0] r;
		case (i)
			CNT_W'(0):  r = 24'd13176795;
			CNT_W'(1):  r = 24'd7778716;
			CNT_W'(2):  r = 24'd4110060;
			CNT_W'(3):  r = 24'd2086331;
			CNT_W'(4):  r = 24'd1047214;
			CNT_W'(5):  r = 24'd524117;
			CNT_W'(6):  r = 24'd262123;
			CNT_W'(7):  r = 24'd131069;
			CNT_W'(8):  r = 24'd65536;
			CNT_W'(9):  r = 24'd32768;
			CNT_W'(10): r = 24'd16384;
			CNT_W'(11): r = 24'd8192;
			CNT_W'(12): r = 24'd4096;
			CNT_W'(13): r = 24'd2048;
			CNT_W'(14): r = 24'd1024;
			CNT_W'(15): r = 24'd512;
			CNT_W'(16): r = 24'd256;
			CNT_W'(17): r = 24'd128;
			CNT_W'(18): r = 24'd64;
			CNT_W'(19): r = 24'd32;
			CNT_W'(20): r = 24'd16;
			CNT_W'(21): r = 24'd8;
			CNT_W'(22): r = 24'd4;
			CNT_W'(23): r = 24'd2;
			default:    r = 24'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/gtp_front.sv -----
// Input queue of the controller: takes pose and target transactions and classifies them.
`default_nettype none
module gtp_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic                                 kind,
	input  logic [gtp_pkg::COORD_W-1:0]          coord_x,
	input  logic [gtp_pkg::COORD_W-1:0]          coord_y,
	input  logic signed [gtp_pkg::HEAD_W-1:0]    heading,
	output logic                                 item_valid,
	input  logic                                 item_ready,
	output gtp_pkg::gtp_item_t                   item
);

	localparam int PTR_W = $clog2(gtp_pkg::FQ_DEPTH);
	localparam int CNT_QW = $clog2(gtp_pkg::FQ_DEPTH + 1);

	gtp_pkg::gtp_item_t  mem_q [gtp_pkg::FQ_DEPTH];
	gtp_pkg::gtp_item_t  wr_item;
	logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNT_QW-1:0]   count_q;
	logic                do_wr, do_rd;

	always_comb begin
		wr_item.kind    = gtp_pkg::gtp_kind_t'(kind);
		wr_item.coord_x = coord_x;
		wr_item.coord_y = coord_y;
		wr_item.heading = (wr_item.kind == gtp_pkg::KIND_TARGET) ? '0 : heading;
	end

	assign full       = (count_q == CNT_QW'(gtp_pkg::FQ_DEPTH));
	assign item_valid = (count_q != '0);
	assign item       = mem_q[rd_ptr_q];
	assign do_wr      = push && !full;
	assign do_rd      = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(gtp_pkg::FQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(gtp_pkg::FQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/gtp_back.sv -----
// Sequencer of the controller: distance, bearing, gate and velocity profile per item, as far as each item needs them.
`default_nettype none
module gtp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  gtp_pkg::gtp_item_t    item,
	input  gtp_pkg::gtp_cfg_t     cfg,
	output logic                  res_valid,
	input  logic                  res_ready,
	output gtp_pkg::gtp_result_t  res
);

	gtp_pkg::gtp_state_t state_q, state_d;
	gtp_pkg::gtp_pstep_t pk_q;

	logic [gtp_pkg::COORD_W-1:0]         tgt_x_q, tgt_y_q, pose_x_q, pose_y_q;
	logic signed [gtp_pkg::HEAD_W-1:0]   pose_hd_q;
	logic [gtp_pkg::VEL_W-1:0]           last_vel_q;
	logic                                moving_q;

	logic signed [gtp_pkg::DIFF_W-1:0]   dx_q, dy_q;
	logic [gtp_pkg::RAD_W-1:0]           dxx_s1, dyy_s1, rad_q;
	logic [gtp_pkg::REM_W-1:0]           rem_q;
	logic [gtp_pkg::ROOT_W-1:0]          root_q;
	logic [gtp_pkg::CNT_W-1:0]           cnt_q;
	logic signed [gtp_pkg::CV_W-1:0]     cx_q, cy_q, cz_q;
	logic signed [gtp_pkg::ANG_W-1:0]    err_q;
	logic [gtp_pkg::VEL_W-1:0]           step_q;
	logic [gtp_pkg::P_W-1:0]             p_q;
	logic [gtp_pkg::W_W-1:0]             w_q;
	logic [gtp_pkg::AV_W-1:0]            av_q;
	logic [gtp_pkg::CMP_W-1:0]           sq_q, coast_q, acc_q;
	gtp_pkg::gtp_result_t                res_q;

	logic                                accept, moving_next;
	logic [gtp_pkg::REM_W-1:0]           rem_sh, trial;
	logic                                rem_ge;
	logic signed [gtp_pkg::CV_W-1:0]     xs, ys, atan_v, x0, y0, bsum;
	logic signed [gtp_pkg::ANG_W-1:0]    mag;
	logic [gtp_pkg::RSA_W-1:0]           rsa;
	logic [gtp_pkg::MX_W-1:0]            mx;
	logic [gtp_pkg::MY_W-1:0]            my;
	logic [gtp_pkg::CMP_W-1:0]           far;
	logic signed [gtp_pkg::NV_W-1:0]     vs, st, nv_raw;
	logic [gtp_pkg::VEL_W-1:0]           nv;
	logic [gtp_pkg::STEP_P_W-1:0]        step_prod;
	logic [gtp_pkg::STEP_X_W-1:0]        step_x;

	assign accept      = item_valid && item_ready;
	assign moving_next = (item.kind == gtp_pkg::KIND_TARGET) || moving_q;

	always_comb begin
		rem_sh = {rem_q[gtp_pkg::REM_W-3:0], rad_q[gtp_pkg::RAD_W-1 -: 2]};
		trial  = {{(gtp_pkg::REM_W - gtp_pkg::ROOT_W - 2){1'b0}}, root_q, 2'b01};
		rem_ge = (rem_sh >= trial);
	end

	always_comb begin
		xs     = cx_q >>> cnt_q;
		ys     = cy_q >>> cnt_q;
		atan_v = gtp_pkg::CV_W'(gtp_pkg::atan_lut(cnt_q));
		x0     = {{(gtp_pkg::CV_W - gtp_pkg::DIFF_W - 8){dx_q[gtp_pkg::DIFF_W-1]}}, dx_q, 8'b0};
		y0     = {{(gtp_pkg::CV_W - gtp_pkg::DIFF_W - 8){dy_q[gtp_pkg::DIFF_W-1]}}, dy_q, 8'b0};
		bsum   = cz_q + gtp_pkg::CV_W'(gtp_pkg::FRAC_ONE / 2);
		mag    = err_q[gtp_pkg::ANG_W-1] ? -err_q : err_q;
	end

	always_comb begin
		rsa = gtp_pkg::RS + gtp_pkg::RSA_W'(cfg.max_accel);
		mx  = '0;
		my  = '0;
		case (pk_q)
			gtp_pkg::PS_W: begin
				mx = gtp_pkg::MX_W'(rsa);
				my = gtp_pkg::MY_W'(last_vel_q);
			end
			gtp_pkg::PS_AV: begin
				mx = gtp_pkg::MX_W'(cfg.max_accel);
				my = gtp_pkg::MY_W'(last_vel_q);
			end
			gtp_pkg::PS_WL: begin
				mx = gtp_pkg::MX_W'(w_q);
				my = gtp_pkg::MY_W'(w_q[gtp_pkg::WL_W-1:0]);
			end
			gtp_pkg::PS_WH: begin
				mx = gtp_pkg::MX_W'(w_q);
				my = gtp_pkg::MY_W'(w_q[gtp_pkg::W_W-1:gtp_pkg::WL_W]);
			end
			gtp_pkg::PS_CROSS: begin
				mx = gtp_pkg::MX_W'(av_q);
				my = gtp_pkg::TWO_R;
			end
			gtp_pkg::PS_AA: begin
				mx = gtp_pkg::MX_W'(cfg.max_accel);
				my = gtp_pkg::MY_W'(cfg.max_accel);
			end
			gtp_pkg::PS_DA: begin
				mx = gtp_pkg::MX_W'(root_q);
				my = gtp_pkg::MY_W'(cfg.max_accel);
			end
			gtp_pkg::PS_FAR: begin
				mx = gtp_pkg::MX_W'(p_q[gtp_pkg::DA_W-1:0]);
				my = gtp_pkg::TWO_R2;
			end
			default: begin
				mx = '0;
				my = '0;
			end
		endcase
	end

	always_comb begin
		step_x    = gtp_pkg::STEP_X_W'(cfg.max_accel) + gtp_pkg::HALF_R;
		step_prod = gtp_pkg::STEP_P_W'(step_x) * gtp_pkg::STEP_P_W'(gtp_pkg::STEP_MUL);
		far       = gtp_pkg::CMP_W'(p_q) << (2 * gtp_pkg::FRAC_SHIFT);
		vs        = signed'({2'b00, last_vel_q});
		st        = signed'({2'b00, step_q});
		if (acc_q < far) begin
			nv_raw = vs + st;
		end else if (!(coast_q < far)) begin
			nv_raw = vs - st;
		end else begin
			nv_raw = vs;
		end
		if (nv_raw > signed'({2'b00, cfg.max_vel})) begin
			nv = cfg.max_vel;
		end else if (nv_raw < 0) begin
			nv = '0;
		end else begin
			nv = nv_raw[gtp_pkg::VEL_W-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gtp_pkg::ST_IDLE: begin
				if (item_valid) begin
					state_d = moving_next ? gtp_pkg::ST_DIFF : gtp_pkg::ST_EMIT;
				end
			end
			gtp_pkg::ST_DIFF:   state_d = gtp_pkg::ST_SQUARE;
			gtp_pkg::ST_SQUARE: state_d = gtp_pkg::ST_SUM;
			gtp_pkg::ST_SUM:    state_d = gtp_pkg::ST_SQRT;
			gtp_pkg::ST_SQRT: begin
				if (cnt_q == gtp_pkg::CNT_W'(gtp_pkg::ROOT_W - 1)) begin
					state_d = gtp_pkg::ST_CHECK;
				end
			end
			gtp_pkg::ST_CHECK: begin
				if (root_q <= gtp_pkg::ROOT_W'(cfg.tolerance)) begin
					state_d = gtp_pkg::ST_EMIT;
				end else begin
					state_d = gtp_pkg::ST_CORDIC;
				end
			end
			gtp_pkg::ST_CORDIC: begin
				if (cnt_q == gtp_pkg::CNT_W'(gtp_pkg::CORDIC_N - 1)) begin
					state_d = gtp_pkg::ST_ERR;
				end
			end
			gtp_pkg::ST_ERR: state_d = gtp_pkg::ST_GATE;
			gtp_pkg::ST_GATE: begin
				if (mag > signed'({3'b000, cfg.heading_gate})) begin
					state_d = gtp_pkg::ST_EMIT;
				end else begin
					state_d = gtp_pkg::ST_PROFILE;
				end
			end
			gtp_pkg::ST_PROFILE: begin
				if (pk_q == gtp_pkg::PS_DONE) begin
					state_d = gtp_pkg::ST_EMIT;
				end
			end
			gtp_pkg::ST_EMIT: begin
				if (res_ready) begin
					state_d = gtp_pkg::ST_IDLE;
				end
			end
			default: state_d = gtp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready = (state_q == gtp_pkg::ST_IDLE);
		res_valid  = (state_q == gtp_pkg::ST_EMIT);
		res        = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= gtp_pkg::ST_IDLE;
			tgt_x_q    <= '0;
			tgt_y_q    <= '0;
			pose_x_q   <= '0;
			pose_y_q   <= '0;
			pose_hd_q  <= '0;
			last_vel_q <= '0;
			moving_q   <= 1'b0;
			cnt_q      <= '0;
			pk_q       <= gtp_pkg::PS_W;
		end else begin
			state_q <= state_d;
			case (state_q)
				gtp_pkg::ST_IDLE: begin
					if (accept) begin
						if (item.kind == gtp_pkg::KIND_TARGET) begin
							tgt_x_q  <= item.coord_x;
							tgt_y_q  <= item.coord_y;
							moving_q <= 1'b1;
						end else begin
							pose_x_q  <= item.coord_x;
							pose_y_q  <= item.coord_y;
							pose_hd_q <= item.heading;
						end
					end
				end
				gtp_pkg::ST_SUM: cnt_q <= '0;
				gtp_pkg::ST_SQRT: begin
					cnt_q <= (state_d == gtp_pkg::ST_SQRT) ? cnt_q + 1'b1 : '0;
				end
				gtp_pkg::ST_CHECK: begin
					cnt_q <= '0;
					if (state_d == gtp_pkg::ST_EMIT) begin
						moving_q <= 1'b0;
					end
				end
				gtp_pkg::ST_CORDIC: cnt_q <= cnt_q + 1'b1;
				gtp_pkg::ST_GATE:   pk_q <= gtp_pkg::PS_W;
				gtp_pkg::ST_PROFILE: begin
					if (pk_q == gtp_pkg::PS_DONE) begin
						last_vel_q <= nv;
					end else begin
						pk_q <= gtp_pkg::gtp_pstep_t'(pk_q + 1'b1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			gtp_pkg::ST_IDLE: begin
				res_q.cmd_valid   <= 1'b0;
				res_q.linear_vel  <= '0;
				res_q.angular_vel <= '0;
				res_q.arrived     <= 1'b1;
			end
			gtp_pkg::ST_DIFF: begin
				dx_q <= signed'({1'b0, tgt_x_q}) - signed'({1'b0, pose_x_q});
				dy_q <= signed'({1'b0, tgt_y_q}) - signed'({1'b0, pose_y_q});
			end
			gtp_pkg::ST_SQUARE: begin
				dxx_s1 <= unsigned'(gtp_pkg::RAD_W'(dx_q) * gtp_pkg::RAD_W'(dx_q));
				dyy_s1 <= unsigned'(gtp_pkg::RAD_W'(dy_q) * gtp_pkg::RAD_W'(dy_q));
			end
			gtp_pkg::ST_SUM: begin
				rad_q  <= dxx_s1 + dyy_s1;
				rem_q  <= '0;
				root_q <= '0;
			end
			gtp_pkg::ST_SQRT: begin
				rad_q <= rad_q << 2;
				if (rem_ge) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[gtp_pkg::ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[gtp_pkg::ROOT_W-2:0], 1'b0};
				end
			end
			gtp_pkg::ST_CHECK: begin
				if (dx_q < 0) begin
					if (dy_q >= 0) begin
						cx_q <= y0;
						cy_q <= -x0;
						cz_q <= gtp_pkg::CV_W'(gtp_pkg::HALF_PI_24);
					end else begin
						cx_q <= -y0;
						cy_q <= x0;
						cz_q <= -gtp_pkg::CV_W'(gtp_pkg::HALF_PI_24);
					end
				end else begin
					cx_q <= x0;
					cy_q <= y0;
					cz_q <= '0;
				end
			end
			gtp_pkg::ST_CORDIC: begin
				if (cy_q > 0) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + atan_v;
				end else begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - atan_v;
				end
			end
			gtp_pkg::ST_ERR: begin
				err_q <= gtp_pkg::ANG_W'(signed'(bsum[gtp_pkg::CV_W-1:gtp_pkg::FRAC_SHIFT]))
					- gtp_pkg::ANG_W'(pose_hd_q);
			end
			gtp_pkg::ST_GATE: begin
				step_q            <= gtp_pkg::VEL_W'(step_prod >> gtp_pkg::STEP_SHIFT);
				res_q.cmd_valid   <= 1'b1;
				res_q.linear_vel  <= '0;
				res_q.angular_vel <= err_q;
				res_q.arrived     <= 1'b0;
			end
			gtp_pkg::ST_PROFILE: begin
				p_q <= gtp_pkg::P_W'(mx) * gtp_pkg::P_W'(my);
				case (pk_q)
					gtp_pkg::PS_AV: w_q  <= p_q[gtp_pkg::W_W-1:0];
					gtp_pkg::PS_WL: av_q <= p_q[gtp_pkg::AV_W-1:0];
					gtp_pkg::PS_WH: sq_q <= gtp_pkg::CMP_W'(p_q);
					gtp_pkg::PS_CROSS: begin
						sq_q <= sq_q + (gtp_pkg::CMP_W'(p_q) << gtp_pkg::WL_W);
					end
					gtp_pkg::PS_AA: begin
						coast_q <= sq_q + (gtp_pkg::CMP_W'(p_q) << (2 * gtp_pkg::FRAC_SHIFT));
					end
					gtp_pkg::PS_DA: begin
						acc_q <= coast_q + (gtp_pkg::CMP_W'(p_q) << (2 * gtp_pkg::FRAC_SHIFT + 1));
					end
					gtp_pkg::PS_DONE: begin
						res_q.linear_vel  <= nv;
						res_q.angular_vel <= {err_q[gtp_pkg::ANG_W-2:0], 1'b0};
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	a_cmd_xor_arrived: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.cmd_valid != res.arrived))
		else $error("command and arrival flags agree");

	a_idle_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.cmd_valid) |-> (res.linear_vel == '0 && res.angular_vel == '0))
		else $error("no-command result carries a velocity");

	a_vel_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.linear_vel <= cfg.max_vel))
		else $error("forward velocity above ceiling");

	a_arrived_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.arrived) |-> !moving_q)
		else $error("arrival reported while still moving");

	a_fwd_tracks_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.linear_vel != '0) |-> (res.linear_vel == last_vel_q))
		else $error("forward command differs from stored velocity");

endmodule
`default_nettype wire

// ----- hw/rtl/goto_point_trapezoid_controller.sv -----
// Top level of the go-to-point trapezoid controller: configuration, input queue, sequencer, result queue.
// Usage:
//   Input channel is a queue: drive kind, coord_x, coord_y, heading and raise push while
//   full is low; kind 0 is a pose update, kind 1 a new target. Every input transaction
//   yields exactly one result transaction, in order.
//   Result channel is a queue: while empty is low the oldest result is on cmd_valid,
//   linear_vel, angular_vel and arrived; raise pop to take it.
//   Configuration: cfg_index selects tolerance, max_accel, max_vel or heading_gate;
//   cfg_ready is always high. Write only while no transaction is in flight.
//   The sequencer handles one item at a time and takes the next one the cycle after its
//   result enters the result queue. A pose update while not moving goes straight to its
//   result; an arrival runs the distance and its square-root loop; a rotate-only command
//   adds the 16 CORDIC iterations and the heading gate, and a forward command adds the
//   steps of the velocity profile.
//   Two inputs and two results can wait in the queues, so push is taken while a result
//   waits; if pop stays low the result queue fills and the sequencer holds its result.
//   Reset clears pose, target, velocity and moving flag and loads the default register
//   values; no clearing pass is needed.
`default_nettype none
module goto_point_trapezoid_controller (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	output logic                                   full,
	input  logic                                   kind,
	input  logic [gtp_pkg::COORD_W-1:0]            coord_x,
	input  logic [gtp_pkg::COORD_W-1:0]            coord_y,
	input  logic signed [gtp_pkg::HEAD_W-1:0]      heading,
	output logic                                   empty,
	input  logic                                   pop,
	output logic                                   cmd_valid,
	output logic [gtp_pkg::VEL_W-1:0]              linear_vel,
	output logic signed [gtp_pkg::ANG_W-1:0]       angular_vel,
	output logic                                   arrived,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [gtp_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [gtp_pkg::CFG_DATA_W-1:0]         cfg_data
);

	localparam int PTR_W  = $clog2(gtp_pkg::RQ_DEPTH);
	localparam int CNT_QW = $clog2(gtp_pkg::RQ_DEPTH + 1);

	gtp_pkg::gtp_cfg_t     cfg_q;
	gtp_pkg::gtp_item_t    item;
	gtp_pkg::gtp_result_t  res, head;
	gtp_pkg::gtp_result_t  rq_mem_q [gtp_pkg::RQ_DEPTH];
	logic                  item_valid, item_ready, res_valid, res_ready;
	logic [PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [CNT_QW-1:0]     count_q;
	logic                  do_wr, do_rd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tolerance    <= gtp_pkg::TOL_RST;
			cfg_q.max_accel    <= gtp_pkg::ACCEL_RST;
			cfg_q.max_vel      <= gtp_pkg::VMAX_RST;
			cfg_q.heading_gate <= gtp_pkg::GATE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (gtp_pkg::gtp_reg_t'(cfg_index))
				gtp_pkg::REG_TOLERANCE:    cfg_q.tolerance    <= cfg_data[gtp_pkg::TOL_W-1:0];
				gtp_pkg::REG_MAX_ACCEL:    cfg_q.max_accel    <= cfg_data[gtp_pkg::VEL_W-1:0];
				gtp_pkg::REG_MAX_VEL:      cfg_q.max_vel      <= cfg_data[gtp_pkg::VEL_W-1:0];
				gtp_pkg::REG_HEADING_GATE: cfg_q.heading_gate <= cfg_data[gtp_pkg::VEL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	gtp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.kind       (kind),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.heading    (heading),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	gtp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cfg        (cfg_q),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	assign res_ready = (count_q != CNT_QW'(gtp_pkg::RQ_DEPTH));
	assign empty     = (count_q == '0);
	assign do_wr     = res_valid && res_ready;
	assign do_rd     = pop && !empty;
	assign head      = rq_mem_q[rd_ptr_q];

	assign cmd_valid   = head.cmd_valid;
	assign linear_vel  = head.linear_vel;
	assign angular_vel = head.angular_vel;
	assign arrived     = head.arrived;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(gtp_pkg::RQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(gtp_pkg::RQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			rq_mem_q[wr_ptr_q] <= res;
		end
	end

endmodule
`default_nettype wire

// ----- dv/goto_point_trapezoid_controller_test.sv -----
// Self-checking testbench for the go-to-point trapezoid controller, with a prediction scoreboard.
`timescale 1ns / 100ps
module goto_point_trapezoid_controller_test;

	class motion_scoreboard;
		int unsigned goal_x, goal_y, at_x, at_y, prev_vel;
		int facing;
		bit in_motion;
		int unsigned tol, accel, vmax, gate;
		gtp_pkg::gtp_result_t awaited[$];
		int errors, results_seen, commands_seen, forward_seen;
		longint atan_q24[16] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
			262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512};

		function void clear();
			goal_x = 0; goal_y = 0; at_x = 0; at_y = 0; facing = 0;
			prev_vel = 0; in_motion = 0;
			tol = 41; accel = 2048; vmax = 8192; gate = 819;
		endfunction

		function void write_reg(gtp_pkg::gtp_reg_t idx, int unsigned val);
			case (idx)
				gtp_pkg::REG_TOLERANCE:    tol = val & 12'hFFF;
				gtp_pkg::REG_MAX_ACCEL:    accel = val & 14'h3FFF;
				gtp_pkg::REG_MAX_VEL:      vmax = val & 14'h3FFF;
				gtp_pkg::REG_HEADING_GATE: gate = val & 14'h3FFF;
				default: begin
				end
			endcase
		endfunction

		function longint unsigned root_floor(longint unsigned n);
			longint unsigned res, bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > n) bitv >>= 2;
			while (bitv != 0) begin
				if (n >= res + bitv) begin
					n -= res + bitv;
					res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		function int bearing_of(longint dx, longint dy);
			longint x, y, z, t, xs, ys;
			x = dx * 256; y = dy * 256; z = 0;
			if (x < 0) begin
				if (y >= 0) begin
					t = x; x = y; y = -t; z = gtp_pkg::HALF_PI_24;
				end else begin
					t = x; x = -y; y = t; z = -gtp_pkg::HALF_PI_24;
				end
			end
			for (int i = 0; i < 16; i++) begin
				xs = x >>> i; ys = y >>> i;
				if (y > 0) begin
					x += ys; y -= xs; z += atan_q24[i];
				end else begin
					x -= ys; y += xs; z -= atan_q24[i];
				end
			end
			return int'((z + 2048) >>> 12);
		endfunction

		function int unsigned profile_vel(longint unsigned span);
			logic [127:0] v, a, d, rs, rsa, coast, acc, far;
			longint nv, stp;
			v = prev_vel; a = accel; d = span;
			rs = 62 * 4096;
			rsa = rs + a;
			coast = 2 * a * v * rs * 4096 + v * v * rsa * rsa;
			acc = coast + 2 * a * a * 4096 * 4096;
			far = 2 * d * a * 62 * 62 * 4096 * 4096;
			stp = (accel + 31) / 62;
			nv = prev_vel;
			if (acc < far) nv += stp;
			else if (!(coast < far)) nv -= stp;
			if (longint'(vmax) < nv) nv = vmax;
			if (nv < 0) nv = 0;
			return int'(nv);
		endfunction

		function void note_item(bit k, bit [15:0] x, bit [15:0] y, bit signed [14:0] h);
			gtp_pkg::gtp_result_t r;
			longint dx, dy, err, mag, ang;
			longint unsigned span;
			r = '0;
			ang = 0;
			if (k == gtp_pkg::KIND_TARGET) begin
				goal_x = x; goal_y = y; in_motion = 1;
			end else begin
				at_x = x; at_y = y; facing = h;
			end
			if (in_motion) begin
				dx = longint'(goal_x) - longint'(at_x);
				dy = longint'(goal_y) - longint'(at_y);
				span = root_floor(dx * dx + dy * dy);
				if (span > tol) begin
					err = bearing_of(dx, dy) - facing;
					mag = err < 0 ? -err : err;
					r.cmd_valid = 1;
					if (mag > gate) begin
						ang = err;
					end else begin
						prev_vel = profile_vel(span);
						r.linear_vel = prev_vel[13:0];
						ang = 2 * err;
					end
				end else begin
					in_motion = 0;
				end
			end
			r.angular_vel = ang[16:0];
			r.arrived = !in_motion;
			awaited.push_back(r);
		endfunction

		function void check_result(gtp_pkg::gtp_result_t got);
			gtp_pkg::gtp_result_t e;
			results_seen++;
			if (awaited.size() == 0) begin
				$error("result transaction with nothing expected");
				errors++;
				return;
			end
			e = awaited.pop_front();
			if (got.cmd_valid) commands_seen++;
			if (got.linear_vel != 0) forward_seen++;
			if (got.cmd_valid !== e.cmd_valid) begin
				$error("cmd_valid expected %0d actual %0d", e.cmd_valid, got.cmd_valid);
				errors++;
			end
			if (got.linear_vel !== e.linear_vel) begin
				$error("linear_vel expected %0d actual %0d", e.linear_vel, got.linear_vel);
				errors++;
			end
			if (got.angular_vel !== e.angular_vel) begin
				$error("angular_vel expected %0d actual %0d", e.angular_vel,
					got.angular_vel);
				errors++;
			end
			if (got.arrived !== e.arrived) begin
				$error("arrived expected %0d actual %0d", e.arrived, got.arrived);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, push, full, kind, empty, pop;
	logic [gtp_pkg::COORD_W-1:0] coord_x, coord_y;
	logic signed [gtp_pkg::HEAD_W-1:0] heading;
	logic cmd_valid, arrived, cfg_valid, cfg_ready;
	logic [gtp_pkg::VEL_W-1:0] linear_vel;
	logic signed [gtp_pkg::ANG_W-1:0] angular_vel;
	logic [gtp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [gtp_pkg::CFG_DATA_W-1:0] cfg_data;

	motion_scoreboard ctrl = new();
	int burst_left, items_sent, cycles;
	int unsigned px, py, tx, ty;

	goto_point_trapezoid_controller dut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				ctrl.check_result('{cmd_valid, linear_vel, angular_vel, arrived});
			case ((cycles / 300) % 3)
				0: pop <= 1'b1;
				1: pop <= $urandom_range(0, 1);
				default: pop <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	task automatic send(bit k, int unsigned x, int unsigned y, int h);
		if (burst_left <= 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(1, 12);
		end
		push <= 1'b1;
		kind <= k;
		coord_x <= x[15:0];
		coord_y <= y[15:0];
		heading <= h[14:0];
		do @(posedge clk); while (full);
		ctrl.note_item(k, x[15:0], y[15:0], h[14:0]);
		burst_left--;
		items_sent++;
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (ctrl.awaited.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_cfg(gtp_pkg::gtp_reg_t idx, int unsigned val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[13:0];
		do @(posedge clk); while (!cfg_ready);
		ctrl.write_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_all(int unsigned t, int unsigned a, int unsigned v, int unsigned g);
		write_cfg(gtp_pkg::REG_TOLERANCE, t);
		write_cfg(gtp_pkg::REG_MAX_ACCEL, a);
		write_cfg(gtp_pkg::REG_MAX_VEL, v);
		write_cfg(gtp_pkg::REG_HEADING_GATE, g);
	endtask

	function automatic int aim_heading(int spread);
		if (tx == px && ty == py) return 0;
		return ctrl.bearing_of(longint'(tx) - longint'(px), longint'(ty) - longint'(py))
			+ $urandom_range(0, 2 * spread) - spread;
	endfunction

	task automatic approach_run();
		int n, k;
		if ($urandom_range(0, 1)) begin
			tx = $urandom_range(0, 45383); ty = $urandom_range(0, 45383);
		end else begin
			tx = (px + $urandom_range(0, 2000) + 65536 - 1000) % 65536;
			ty = (py + $urandom_range(0, 2000) + 65536 - 1000) % 65536;
		end
		send(gtp_pkg::KIND_TARGET, tx, ty, $urandom);
		n = $urandom_range(3, 14);
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(1, 8);
			px = int'(px) + (int'(tx) - int'(px)) * k / 8;
			py = int'(py) + (int'(ty) - int'(py)) * k / 8;
			send(gtp_pkg::KIND_POSE, px, py, aim_heading($urandom_range(0, 1) ? 100 : 1500));
		end
	endtask

	task automatic random_phase(int count);
		int start;
		start = items_sent;
		while (items_sent - start < count) begin
			if ($urandom_range(0, 9) == 0)
				send($urandom_range(0, 1), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom);
			else
				approach_run();
		end
	endtask

	initial begin
		clk = 0; arst_n = 0; push = 0; pop = 0; kind = 0;
		coord_x = 0; coord_y = 0; heading = 0;
		cfg_valid = 0; cfg_index = gtp_pkg::REG_TOLERANCE; cfg_data = 0;
		cycles = 0; burst_left = 0; items_sent = 0; px = 0; py = 0;
		ctrl.clear();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(gtp_pkg::KIND_POSE, 0, 0, 0);
		send(gtp_pkg::KIND_POSE, 45383, 45383, 12868);
		send(gtp_pkg::KIND_POSE, 65535, 65535, -16384);
		send(gtp_pkg::KIND_TARGET, 65535, 65535, 16383);
		send(gtp_pkg::KIND_POSE, 0, 0, 3217);
		send(gtp_pkg::KIND_POSE, 0, 0, 3300);
		send(gtp_pkg::KIND_POSE, 65535, 65535, 0);
		send(gtp_pkg::KIND_TARGET, 0, 45383, 0);
		send(gtp_pkg::KIND_POSE, 45383, 0, 9651);
		send(gtp_pkg::KIND_POSE, 45383, 0, -12868);
		send(gtp_pkg::KIND_TARGET, 0, 0, 0);
		send(gtp_pkg::KIND_POSE, 45383, 45383, -9651);
		send(gtp_pkg::KIND_POSE, 45383, 45383, 12868);
		send(gtp_pkg::KIND_TARGET, 100, 0, 0);
		send(gtp_pkg::KIND_POSE, 60, 0, 0);
		send(gtp_pkg::KIND_POSE, 0, 0, 0);
		send(gtp_pkg::KIND_TARGET, 20000, 20000, 0);
		send(gtp_pkg::KIND_POSE, 20000, 20000, 0);
		send(gtp_pkg::KIND_POSE, 19000, 20000, 0);
		random_phase(150);
		drain();

		set_all(4095, 16383, 16383, 16383);
		random_phase(200);
		drain();
		set_all(0, 0, 0, 0);
		random_phase(150);
		drain();
		set_all(0, 1, 16383, 16383);
		random_phase(200);
		drain();
		set_all(41, 2048, 8192, 819);
		random_phase(200);
		drain();
		for (int p = 0; p < 4; p++) begin
			set_all($urandom_range(0, 300), $urandom_range(1, 16383),
				$urandom_range(0, 16383), $urandom_range(200, 16383));
			random_phase(180);
			drain();
		end

		$display("Covered %0d input items, %0d results, %0d commands, %0d forward moves.",
			items_sent, ctrl.results_seen, ctrl.commands_seen, ctrl.forward_seen);
		$display("Nine register settings, zero and full-scale values among them.");
		if (ctrl.errors == 0 && ctrl.awaited.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
